@@ rtl/ax25ufb_pkg.sv @@
package ax25ufb_pkg;

    // frame delimiter, address field and fcs constants
    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] SSID_BASE   = 8'h60;
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [15:0] FCS_INVERT = 16'hFFFF;

    // register map indexes
    localparam logic [2:0] REG_DEST_CALL = 3'd0;
    localparam logic [2:0] REG_DEST_SSID = 3'd1;
    localparam logic [2:0] REG_SRC_CALL  = 3'd2;
    localparam logic [2:0] REG_SRC_SSID  = 3'd3;
    localparam logic [2:0] REG_CONTROL   = 3'd4;
    localparam logic [2:0] REG_PID       = 3'd5;
    localparam logic [2:0] REG_CRC_POLY  = 3'd6;
    localparam logic [2:0] REG_CRC_SEED  = 3'd7;

    // register reset values
    localparam logic [47:0] DEST_CALL_RST = 48'd73870815846432;
    localparam logic [3:0]  DEST_SSID_RST = 4'd0;
    localparam logic [47:0] SRC_CALL_RST  = 48'd35322350018592;
    localparam logic [3:0]  SRC_SSID_RST  = 4'd1;
    localparam logic [7:0]  CONTROL_RST   = 8'd3;
    localparam logic [7:0]  PID_RST       = 8'd240;
    localparam logic [15:0] CRC_POLY_RST  = 16'd33800;
    localparam logic [15:0] CRC_SEED_RST  = 16'd65535;

    // byte positions within one frame
    localparam logic [4:0] POS_FLAG_OPEN  = 5'd0;
    localparam logic [4:0] POS_DEST       = 5'd1;
    localparam logic [4:0] POS_DEST_END   = 5'd6;
    localparam logic [4:0] POS_DEST_SSID  = 5'd7;
    localparam logic [4:0] POS_SRC        = 5'd8;
    localparam logic [4:0] POS_SRC_END    = 5'd13;
    localparam logic [4:0] POS_SRC_SSID   = 5'd14;
    localparam logic [4:0] POS_CTRL       = 5'd15;
    localparam logic [4:0] POS_PID        = 5'd16;
    localparam logic [4:0] POS_INFO       = 5'd17;
    localparam logic [4:0] POS_FCS_LO     = 5'd18;
    localparam logic [4:0] POS_FCS_HI     = 5'd19;
    localparam logic [4:0] POS_FLAG_CLOSE = 5'd20;

endpackage

@@ rtl/ax25_ui_frame_builder.sv @@
// an accepted input transaction goes to the held item registers; its bytes are then
// loaded into the output register, one output byte per cycle while m_tready allows
// (17 header bytes on the first item, one info byte, 3 closing bytes)
// the output register sets the pace: the next item is taken as the current one's
// last byte is loaded, and a dropped item with no output is taken without going busy
// reset: asynchronous active-low rst_n clears control state and loads register defaults
module ax25_ui_frame_builder #(
    parameter int MAX_INFO_LEN = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // information byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] info_byte
    input  logic        s_tlast,   // last_byte
    // frame byte stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // run_last
    output logic [1:0]  m_tuser    // [0] frame_end, [1] overflow
);
    import ax25ufb_pkg::*;

    localparam int CW = $clog2(MAX_INFO_LEN + 1);

    // crc over one byte, reflected, eight shift steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ poly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // callsign to six address bytes: upper case, spaces from a zero char on, shifted left
    function automatic logic [5:0][7:0] encode_call(input logic [47:0] cs);
        logic [5:0][7:0] res;
        logic            ended;
        logic [7:0]      ch;
        ended = 1'b0;
        for (int i = 0; i < 6; i++) begin
            ch = cs[47 - 8*i -: 8];
            if (ended || ch == 8'h00) begin
                ended = 1'b1;
                ch    = SPACE_CHAR;
            end
            if (ch >= LOWER_A && ch <= LOWER_Z)
                ch = ch - CASE_OFFSET;
            res[i] = {ch[6:0], 1'b0};
        end
        return res;
    endfunction

    // configuration registers
    logic [47:0] dest_call_reg;
    logic [3:0]  dest_ssid_reg;
    logic [47:0] src_call_reg;
    logic [3:0]  src_ssid_reg;
    logic [7:0]  control_reg;
    logic [7:0]  pid_reg;
    logic [15:0] crc_poly_reg;
    logic [15:0] crc_seed_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_call_reg <= DEST_CALL_RST;
            dest_ssid_reg <= DEST_SSID_RST;
            src_call_reg  <= SRC_CALL_RST;
            src_ssid_reg  <= SRC_SSID_RST;
            control_reg   <= CONTROL_RST;
            pid_reg       <= PID_RST;
            crc_poly_reg  <= CRC_POLY_RST;
            crc_seed_reg  <= CRC_SEED_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_DEST_CALL: dest_call_reg <= pwdata[47:0];
                REG_DEST_SSID: dest_ssid_reg <= pwdata[3:0];
                REG_SRC_CALL:  src_call_reg  <= pwdata[47:0];
                REG_SRC_SSID:  src_ssid_reg  <= pwdata[3:0];
                REG_CONTROL:   control_reg   <= pwdata[7:0];
                REG_PID:       pid_reg       <= pwdata[7:0];
                REG_CRC_POLY:  crc_poly_reg  <= pwdata[15:0];
                REG_CRC_SEED:  crc_seed_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (cfg_idx)
            REG_DEST_CALL: prdata = {16'h0000, dest_call_reg};
            REG_DEST_SSID: prdata = {60'd0, dest_ssid_reg};
            REG_SRC_CALL:  prdata = {16'h0000, src_call_reg};
            REG_SRC_SSID:  prdata = {60'd0, src_ssid_reg};
            REG_CONTROL:   prdata = {56'd0, control_reg};
            REG_PID:       prdata = {56'd0, pid_reg};
            REG_CRC_POLY:  prdata = {48'd0, crc_poly_reg};
            REG_CRC_SEED:  prdata = {48'd0, crc_seed_reg};
            default:       prdata = 64'd0;
        endcase
    end

    // frame state
    logic          in_frame_reg, in_frame_next;
    logic [CW-1:0] info_count_reg, info_count_next;
    logic          dropped_reg, dropped_next;
    logic [15:0]   crc_reg, crc_next;

    // held item
    logic       busy_reg, busy_next;
    logic [4:0] pos_reg, pos_next;
    logic [7:0] item_byte_reg;
    logic       item_last_reg;
    logic       item_info_reg;
    logic       item_ov_reg;

    // output register
    logic       m_tvalid_reg;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       run_last_reg;
    logic       frame_end_reg, frame_end_next;
    logic       overflow_reg, overflow_next;

    logic          slot_free, emit, final_pos, s_fire;
    logic          first, drop, base_drop, feed;
    logic [CW-1:0] base_count;
    logic [4:0]    start_pos, adv_pos;
    logic [5:0][7:0] dest_bytes, src_bytes;
    logic [2:0]    dest_idx, src_idx;
    logic [15:0]   fcs;

    assign dest_bytes = encode_call(dest_call_reg);
    assign src_bytes  = encode_call(src_call_reg);
    assign dest_idx   = 3'(pos_reg - POS_DEST);
    assign src_idx    = 3'(pos_reg - POS_SRC);
    assign fcs        = crc_reg ^ FCS_INVERT;

    // handshake
    assign slot_free = !m_tvalid_reg || m_tready;
    assign emit      = busy_reg && slot_free;
    assign s_tready  = !busy_reg || (emit && final_pos);
    assign s_fire    = s_tvalid && s_tready;

    // position sequencing of the held item
    always_comb
    begin
        final_pos = 1'b0;
        adv_pos   = pos_reg + 5'd1;
        case (pos_reg)
            POS_PID:
            begin
                if (item_info_reg)
                    adv_pos = POS_INFO;
                else if (item_last_reg)
                    adv_pos = POS_FCS_LO;
                else
                    final_pos = 1'b1;
            end
            POS_INFO:       final_pos = !item_last_reg;
            POS_FLAG_CLOSE: final_pos = 1'b1;
            default: ;
        endcase
    end

    // byte selection and crc update
    always_comb
    begin
        out_byte_next  = FLAG_BYTE;
        frame_end_next = 1'b0;
        overflow_next  = 1'b0;
        feed           = 1'b0;
        crc_next       = crc_reg;
        case (pos_reg) inside
            POS_FLAG_OPEN:  crc_next = crc_seed_reg;
            [POS_DEST:POS_DEST_END]:
            begin
                out_byte_next = dest_bytes[dest_idx];
                feed          = 1'b1;
            end
            POS_DEST_SSID:
            begin
                out_byte_next = SSID_BASE | {3'b000, dest_ssid_reg, 1'b0};
                feed          = 1'b1;
            end
            [POS_SRC:POS_SRC_END]:
            begin
                out_byte_next = src_bytes[src_idx];
                feed          = 1'b1;
            end
            POS_SRC_SSID:
            begin
                out_byte_next = SSID_BASE | {3'b000, src_ssid_reg, 1'b1};
                feed          = 1'b1;
            end
            POS_CTRL:
            begin
                out_byte_next = control_reg;
                feed          = 1'b1;
            end
            POS_PID:
            begin
                out_byte_next = pid_reg;
                feed          = 1'b1;
            end
            POS_INFO:
            begin
                out_byte_next = item_byte_reg;
                feed          = 1'b1;
            end
            POS_FCS_LO:     out_byte_next = fcs[7:0];
            POS_FCS_HI:     out_byte_next = fcs[15:8];
            POS_FLAG_CLOSE:
            begin
                frame_end_next = 1'b1;
                overflow_next  = item_ov_reg;
            end
            default: ;
        endcase
        if (feed)
            crc_next = crc_feed(crc_reg, out_byte_next, crc_poly_reg);
    end

    // frame bookkeeping at input transaction
    always_comb
    begin
        first      = !in_frame_reg;
        base_count = first ? '0 : info_count_reg;
        base_drop  = first ? 1'b0 : dropped_reg;
        drop       = (first && s_tlast) || (base_count >= CW'(MAX_INFO_LEN));
        if (first)
            start_pos = POS_FLAG_OPEN;
        else if (!drop)
            start_pos = POS_INFO;
        else
            start_pos = POS_FCS_LO;

        in_frame_next   = in_frame_reg;
        info_count_next = info_count_reg;
        dropped_next    = dropped_reg;
        busy_next       = busy_reg && !(emit && final_pos);
        pos_next        = emit ? adv_pos : pos_reg;
        if (s_fire)
        begin
            in_frame_next   = !s_tlast;
            info_count_next = s_tlast ? '0 : (drop ? base_count : base_count + CW'(1));
            dropped_next    = s_tlast ? 1'b0 : (base_drop | drop);
            busy_next       = first || !drop || s_tlast;
            pos_next        = start_pos;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            info_count_reg <= '0;
            dropped_reg    <= 1'b0;
            crc_reg        <= 16'h0000;
            busy_reg       <= 1'b0;
            pos_reg        <= POS_FLAG_OPEN;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            info_count_reg <= info_count_next;
            dropped_reg    <= dropped_next;
            busy_reg       <= busy_next;
            pos_reg        <= pos_next;
            if (emit)
                crc_reg <= crc_next;
            if (slot_free)
                m_tvalid_reg <= busy_reg;
        end
    end

    // item and output payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_byte_reg <= s_tdata;
            item_last_reg <= s_tlast;
            item_info_reg <= !drop;
            item_ov_reg   <= s_tlast && (base_drop | drop);
        end
        if (emit)
        begin
            out_byte_reg  <= out_byte_next;
            run_last_reg  <= final_pos;
            frame_end_reg <= frame_end_next;
            overflow_reg  <= overflow_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = run_last_reg;
    assign m_tuser  = {overflow_reg, frame_end_reg};

    // checks
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && m_tvalid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("closing flag not marked as last byte of the transaction");

    a_overflow_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("overflow flagged outside the closing flag");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg <= POS_FLAG_CLOSE))
        else $error("byte position out of frame range");

    a_last_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_tlast) |=> (!in_frame_reg && info_count_reg == '0 && busy_reg))
        else $error("last byte did not close the frame");

endmodule
